FILE: rtl/lra_pkg.sv
// ----------------------------------------------------------------------------
// lra_pkg
// Shared widths, register indexes and result type of the linear scan
// register allocator core.
// ----------------------------------------------------------------------------
package lra_pkg;

  // Register pool.
  localparam int MaxRegs  = 8;
  localparam int PosW     = (MaxRegs > 1) ? $clog2(MaxRegs) : 1;
  localparam int NrW      = $clog2(MaxRegs + 1);

  // Field widths.
  localparam int TempW    = 12;
  localparam int PointW   = 17;
  localparam int EndW     = 16;
  localparam int CntW     = 13;
  localparam int RegIdxW  = 4;
  localparam int OffW     = 16;
  localparam int SizeW    = 5;
  localparam int FirstW   = 3;
  localparam int NumW     = 4;

  // Stream data widths, rounded up to whole bytes.
  localparam int InDataW  = 48;
  localparam int OutDataW = 48;
  localparam int OutPadW  = OutDataW - (TempW + 1 + RegIdxW + OffW + CntW);

  // Configuration port.
  localparam int CfgIdxW  = 2;
  localparam int CfgDataW = 5;

  typedef enum logic [CfgIdxW-1:0] {
    CfgNumRegs   = 2'd0,
    CfgFirstReg  = 2'd1,
    CfgSpillSize = 2'd2
  } cfg_reg_e;

  localparam logic [NumW-1:0]   ResetNumRegs   = 4'd5;
  localparam logic [FirstW-1:0] ResetFirstReg  = 3'd0;
  localparam logic [SizeW-1:0]  ResetSpillSize = 5'd8;

  // Result queue.
  localparam int FifoDepth = 4;
  localparam int FifoPtrW  = $clog2(FifoDepth);
  localparam int FifoCntW  = $clog2(FifoDepth + 1);

  typedef struct packed {
    logic [TempW-1:0]   temp;
    logic               spilled;
    logic [RegIdxW-1:0] reg_idx;
    logic [OffW-1:0]    offset;
    logic               summary;
    logic [CntW-1:0]    total;
    logic               last;
  } result_t;

endpackage

FILE: rtl/linear_scan_register_allocator_core.sv
// ----------------------------------------------------------------------------
// linear_scan_register_allocator_core
// Streaming linear scan register allocator for one register class.
// ----------------------------------------------------------------------------
// Live intervals enter on the s_axis request channel, sorted by start and then
// by end; tuser set marks a finish request. Placements leave on m_axis: one
// result per interval, two when a holder is evicted (the new interval in the
// freed register, then the evicted temp as spilled, with tlast on the second),
// one summary per finish request, none for an ignored interval.
// An accepted request updates the allocator state and queues its results at the
// accepting clock edge. One request is accepted every cycle while s_axis_tready
// is high; the rate is bounded only by the output side, which moves one result
// per cycle while m_axis_tready is high, so an eviction pays for both results.
// Results wait in a four-entry queue; s_axis_tready drops while fewer than two
// entries are free, so a stalled receiver holds back the input side without
// losing results. The config channel is always ready and must only be written
// while the block is idle.
// Reset clears the busy bits, both counters and the queue, and loads the
// register defaults: five registers, first register 0, eight-byte slots.
// ----------------------------------------------------------------------------
module linear_scan_register_allocator_core
  import lra_pkg::*;
(
  input  logic                clk_i,
  input  logic                rst_ni,
  // Configuration writes.
  input  logic                cfg_valid_i,
  output logic                cfg_ready_o,
  input  logic [CfgIdxW-1:0]  cfg_index_i,
  input  logic [CfgDataW-1:0] cfg_data_i,
  // Interval requests.
  input  logic                s_axis_tvalid,
  output logic                s_axis_tready,
  // temp[11:0], in_class[12], def_point[29:13], use_point[46:30], spill_req[47]
  input  logic [InDataW-1:0]  s_axis_tdata,
  // kind[0]
  input  logic                s_axis_tuser,
  // Placement results.
  output logic                m_axis_tvalid,
  input  logic                m_axis_tready,
  // result_temp[11:0], spilled[12], reg_index[16:13], spill_offset[32:17],
  // total_spills[45:33], zero[47:46]
  output logic [OutDataW-1:0] m_axis_tdata,
  // is_summary[0]
  output logic                m_axis_tuser,
  output logic                m_axis_tlast
);

  // Configuration registers.
  logic [NumW-1:0]   num_regs_q, num_regs_d;
  logic [FirstW-1:0] first_reg_q, first_reg_d;
  logic [SizeW-1:0]  spill_size_q, spill_size_d;

  // Allocator state.
  logic [MaxRegs-1:0] busy_q, busy_d;
  logic [EndW-1:0]    end_q   [MaxRegs];
  logic [TempW-1:0]   temp_q  [MaxRegs];
  logic [CntW-1:0]    order_q [MaxRegs];
  logic [CntW-1:0]    insert_q, insert_d;
  logic [CntW-1:0]    spill_q, spill_d;

  // Holder write.
  logic            hw_en;
  logic [PosW-1:0] hw_idx;

  // Result queue.
  result_t              fifo_q [FifoDepth];
  logic [FifoPtrW-1:0]  wr_ptr_q, wr_ptr_d, rd_ptr_q, rd_ptr_d, wr_ptr_nxt;
  logic [FifoCntW-1:0]  cnt_q, cnt_d;
  logic                 push0, push1, pop;
  result_t              res0, res1, head;

  // Request fields.
  logic               accept;
  logic               kind;
  logic [TempW-1:0]   in_temp;
  logic               in_class;
  logic [PointW-1:0]  def_point, use_point;
  logic               spill_req;
  logic [EndW-1:0]    start_pos, end_pos;

  // Decision logic.
  logic [MaxRegs-1:0] busy_rel, elig;
  logic [NrW-1:0]     nr;
  logic               found;
  logic [PosW-1:0]    free_pos;
  logic               have;
  logic [PosW-1:0]    best_pos;
  logic [EndW-1:0]    best_end;
  logic [CntW-1:0]    best_age;
  logic [CntW-1:0]    age;
  logic               evict_ok;
  logic [17:0]        slot_prod;
  logic [OffW-1:0]    slot_off;
  logic [CntW-1:0]    spill_inc;

  assign kind      = s_axis_tuser;
  assign in_temp   = s_axis_tdata[11:0];
  assign in_class  = s_axis_tdata[12];
  assign def_point = s_axis_tdata[29:13];
  assign use_point = s_axis_tdata[46:30];
  assign spill_req = s_axis_tdata[47];

  assign s_axis_tready = (cnt_q <= FifoCntW'(FifoDepth - 2));
  assign accept        = s_axis_tvalid && s_axis_tready;
  assign cfg_ready_o   = 1'b1;

  // An interval ends at the later of its last use and its definition.
  assign start_pos = def_point[EndW-1:0];
  assign end_pos   = ($signed(use_point) >= $signed(def_point)) ? use_point[EndW-1:0]
                                                                : def_point[EndW-1:0];

  assign nr = (num_regs_q > NumW'(MaxRegs)) ? NrW'(MaxRegs) : NrW'(num_regs_q);

  assign slot_prod = 18'(spill_q) * 18'(spill_size_q);
  assign slot_off  = slot_prod[OffW-1:0];
  assign spill_inc = spill_q + CntW'(1);

  // Release expired holders, then look for the lowest free position.
  always_comb begin
    busy_rel = busy_q;
    elig     = '0;
    found    = 1'b0;
    free_pos = '0;
    for (int k = 0; k < MaxRegs; k++) begin
      if (busy_q[k] && (end_q[k] < start_pos)) busy_rel[k] = 1'b0;
      elig[k] = (NrW'(k) < nr);
    end
    for (int k = MaxRegs - 1; k >= 0; k--) begin
      if (elig[k] && !busy_rel[k]) begin
        found    = 1'b1;
        free_pos = PosW'(k);
      end
    end
  end

  // Eviction candidate: largest end, youngest among equal ends, lowest
  // position among full ties.
  always_comb begin
    have     = 1'b0;
    best_pos = '0;
    best_end = '0;
    best_age = '0;
    age      = '0;
    for (int k = 0; k < MaxRegs; k++) begin
      age = insert_q - order_q[k];
      if (elig[k] && (!have || (end_q[k] > best_end) ||
                      ((end_q[k] == best_end) && (age < best_age)))) begin
        have     = 1'b1;
        best_pos = PosW'(k);
        best_end = end_q[k];
        best_age = age;
      end
    end
  end

  assign evict_ok = have && (best_end > end_pos);

  // Request handling.
  always_comb begin
    busy_d   = busy_q;
    insert_d = insert_q;
    spill_d  = spill_q;
    hw_en    = 1'b0;
    hw_idx   = '0;
    push0    = 1'b0;
    push1    = 1'b0;
    res0     = '0;
    res1     = '0;
    if (accept) begin
      if (kind) begin
        push0        = 1'b1;
        res0.summary = 1'b1;
        res0.total   = spill_q;
        res0.last    = 1'b1;
        busy_d       = '0;
        insert_d     = '0;
        spill_d      = '0;
      end else if (in_class && !def_point[PointW-1]) begin
        busy_d    = busy_rel;
        push0     = 1'b1;
        res0.temp = in_temp;
        res0.last = 1'b1;
        if (spill_req || (nr == '0)) begin
          res0.spilled = 1'b1;
          res0.offset  = slot_off;
          res0.total   = spill_inc;
          spill_d      = spill_inc;
        end else if (found) begin
          busy_d[free_pos] = 1'b1;
          hw_en            = 1'b1;
          hw_idx           = free_pos;
          insert_d         = insert_q + CntW'(1);
          res0.reg_idx     = RegIdxW'(first_reg_q) + RegIdxW'(free_pos);
          res0.total       = spill_q;
        end else if (evict_ok) begin
          hw_en        = 1'b1;
          hw_idx       = best_pos;
          insert_d     = insert_q + CntW'(1);
          spill_d      = spill_inc;
          res0.reg_idx = RegIdxW'(first_reg_q) + RegIdxW'(best_pos);
          res0.total   = spill_inc;
          res0.last    = 1'b0;
          push1        = 1'b1;
          res1.temp    = temp_q[best_pos];
          res1.spilled = 1'b1;
          res1.offset  = slot_off;
          res1.total   = spill_inc;
          res1.last    = 1'b1;
        end else begin
          res0.spilled = 1'b1;
          res0.offset  = slot_off;
          res0.total   = spill_inc;
          spill_d      = spill_inc;
        end
      end
    end
  end

  // Configuration writes.
  always_comb begin
    num_regs_d   = num_regs_q;
    first_reg_d  = first_reg_q;
    spill_size_d = spill_size_q;
    if (cfg_valid_i) begin
      case (cfg_reg_e'(cfg_index_i))
        CfgNumRegs:   num_regs_d   = cfg_data_i[NumW-1:0];
        CfgFirstReg:  first_reg_d  = cfg_data_i[FirstW-1:0];
        CfgSpillSize: spill_size_d = cfg_data_i[SizeW-1:0];
        default: ;
      endcase
    end
  end

  // Queue pointers.
  assign pop        = m_axis_tvalid && m_axis_tready;
  assign wr_ptr_nxt = wr_ptr_q + FifoPtrW'(1);
  assign wr_ptr_d   = wr_ptr_q + FifoPtrW'(push0) + FifoPtrW'(push1);
  assign rd_ptr_d   = rd_ptr_q + FifoPtrW'(pop);
  assign cnt_d      = cnt_q + FifoCntW'(push0) + FifoCntW'(push1) - FifoCntW'(pop);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      num_regs_q   <= ResetNumRegs;
      first_reg_q  <= ResetFirstReg;
      spill_size_q <= ResetSpillSize;
      busy_q       <= '0;
      insert_q     <= '0;
      spill_q      <= '0;
      wr_ptr_q     <= '0;
      rd_ptr_q     <= '0;
      cnt_q        <= '0;
    end else begin
      num_regs_q   <= num_regs_d;
      first_reg_q  <= first_reg_d;
      spill_size_q <= spill_size_d;
      busy_q       <= busy_d;
      insert_q     <= insert_d;
      spill_q      <= spill_d;
      wr_ptr_q     <= wr_ptr_d;
      rd_ptr_q     <= rd_ptr_d;
      cnt_q        <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (hw_en) begin
      end_q[hw_idx]   <= end_pos;
      temp_q[hw_idx]  <= in_temp;
      order_q[hw_idx] <= insert_q;
    end
    for (int i = 0; i < FifoDepth; i++) begin
      if (push0 && (wr_ptr_q == FifoPtrW'(i))) begin
        fifo_q[i] <= res0;
      end else if (push1 && (wr_ptr_nxt == FifoPtrW'(i))) begin
        fifo_q[i] <= res1;
      end
    end
  end

  assign head          = fifo_q[rd_ptr_q];
  assign m_axis_tvalid = (cnt_q != '0);
  assign m_axis_tdata  = {{OutPadW{1'b0}}, head.total, head.offset, head.reg_idx,
                          head.spilled, head.temp};
  assign m_axis_tuser  = head.summary;
  assign m_axis_tlast  = head.last;

endmodule

FILE: rtl/lra_checker.sv
// ----------------------------------------------------------------------------
// lra_checker
// Port-level checks of the linear scan register allocator core.
// ----------------------------------------------------------------------------
module lra_checker
  import lra_pkg::*;
(
  input logic                clk_i,
  input logic                rst_ni,
  input logic                cfg_valid_i,
  input logic                cfg_ready_o,
  input logic [CfgIdxW-1:0]  cfg_index_i,
  input logic [CfgDataW-1:0] cfg_data_i,
  input logic                s_axis_tvalid,
  input logic                s_axis_tready,
  input logic [InDataW-1:0]  s_axis_tdata,
  input logic                s_axis_tuser,
  input logic                m_axis_tvalid,
  input logic                m_axis_tready,
  input logic [OutDataW-1:0] m_axis_tdata,
  input logic                m_axis_tuser,
  input logic                m_axis_tlast
);

  // A stalled result stays offered.
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid)
    else $error("result dropped while stalled");

  // A summary carries only the spill total and always closes its request.
  a_summary: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && m_axis_tuser |-> m_axis_tlast && (m_axis_tdata[32:0] == '0))
    else $error("malformed summary result");

  // A spilled result never names a register.
  a_spill_reg: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && m_axis_tdata[12] |-> (m_axis_tdata[16:13] == '0))
    else $error("spilled result with a register number");

  // The first result of an eviction is a register grant and its spilled
  // victim is queued right behind it.
  a_evict_pair: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && m_axis_tready && !m_axis_tlast |->
      !m_axis_tdata[12] && !m_axis_tuser ##1 m_axis_tvalid && m_axis_tdata[12] &&
      m_axis_tlast)
    else $error("eviction result pair broken");

endmodule

bind linear_scan_register_allocator_core lra_checker u_lra_checker (.*);

FILE: verif/tb_linear_scan_register_allocator_core.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_linear_scan_register_allocator_core
// Self-checking testbench for the linear scan register allocator core.
// ----------------------------------------------------------------------------
// An initial block programs the registers while the core is idle and fills a
// queue of interval requests. A clocked driver offers them on s_axis. Every
// accepted request runs through a local allocation model that queues the
// placements it expects. A clocked monitor compares each m_axis result field
// by field. Requests come as directed cases and random sorted functions mixed
// with noise. Both sides idle at random, and one phase stalls the receiver
// long enough to back up the input.
// ----------------------------------------------------------------------------
module tb_linear_scan_register_allocator_core;
  import lra_pkg::*;

  localparam int ClkHalf    = 10;
  localparam int CycleLimit = 1_000_000;
  localparam int TailCycles = 10;
  localparam int LongHold   = 300;

  typedef struct packed {
    logic              kind;
    logic              spill_req;
    logic [PointW-1:0] use_point;
    logic [PointW-1:0] def_point;
    logic              in_class;
    logic [TempW-1:0]  temp;
  } interval_t;

  logic                clk_i         = 1'b0;
  logic                rst_ni        = 1'b0;
  logic                cfg_valid_i   = 1'b0;
  logic                cfg_ready_o;
  logic [CfgIdxW-1:0]  cfg_index_i   = '0;
  logic [CfgDataW-1:0] cfg_data_i    = '0;
  logic                s_axis_tvalid = 1'b0;
  logic                s_axis_tready;
  logic [InDataW-1:0]  s_axis_tdata  = '0;
  logic                s_axis_tuser  = 1'b0;
  logic                m_axis_tvalid;
  logic                m_axis_tready = 1'b0;
  logic [OutDataW-1:0] m_axis_tdata;
  logic                m_axis_tuser;
  logic                m_axis_tlast;

  linear_scan_register_allocator_core uut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cfg_valid_i   (cfg_valid_i),
    .cfg_ready_o   (cfg_ready_o),
    .cfg_index_i   (cfg_index_i),
    .cfg_data_i    (cfg_data_i),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser),
    .m_axis_tlast  (m_axis_tlast)
  );

  always #(ClkHalf) clk_i = ~clk_i;

  // Allocation model state.
  logic [NumW-1:0]   m_num;
  logic [FirstW-1:0] m_first;
  logic [SizeW-1:0]  m_size;
  logic              reg_held   [MaxRegs];
  logic [EndW-1:0]   held_end   [MaxRegs];
  logic [TempW-1:0]  held_temp  [MaxRegs];
  logic [CntW-1:0]   held_order [MaxRegs];
  logic [CntW-1:0]   grant_seq;
  logic [CntW-1:0]   slot_cnt;

  interval_t interval_q[$];
  result_t   placement_q[$];

  int queued_cnt   = 0;
  int sent_cnt     = 0;
  int checked_cnt  = 0;
  int evict_cnt    = 0;
  int spill_cnt    = 0;
  int summary_cnt  = 0;
  int err_cnt      = 0;
  int cycle_cnt    = 0;

  logic      drv_gaps_on = 1'b0;
  logic      rcv_gaps_on = 1'b0;
  logic      hold_go     = 1'b0;
  logic [8:0] hold_cnt   = '0;
  interval_t drv_item;
  logic      drv_offer;
  int        drv_gap = 0;
  int        rcv_gap = 0;
  result_t   mon_got;
  result_t   mon_want;

  task automatic report_mismatch(input string msg);
    err_cnt++;
    $display("[%0t] mismatch: %s", $time, msg);
  endtask

  task automatic check_field(input string name, input int got, input int want);
    if (got != want) begin
      report_mismatch($sformatf("result %0d %s: got %0d, expected %0d",
                                checked_cnt, name, got, want));
    end
  endtask

  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (r < 75) return $urandom_range(1, 3);
    if (r < 95) return $urandom_range(4, 10);
    return $urandom_range(20, 60);
  endfunction

  // Every placement carries the spill count as it stands after the request; a summary carries the count it clears.
  function automatic result_t placement(input logic [TempW-1:0] t, input logic sp,
                                        input logic [RegIdxW-1:0] r,
                                        input logic [OffW-1:0] off,
                                        input logic summ, input logic lst);
    result_t res;
    res.temp    = t;
    res.spilled = sp;
    res.reg_idx = r;
    res.offset  = off;
    res.summary = summ;
    res.total   = slot_cnt;
    res.last    = lst;
    return res;
  endfunction

  function automatic logic [OffW-1:0] next_slot();
    logic [OffW-1:0] off;
    off = OffW'(int'(slot_cnt) * int'(m_size));
    slot_cnt = slot_cnt + CntW'(1);
    return off;
  endfunction

  task automatic place_interval(input interval_t it);
    int start_pos, lu_pos, fin_pos, nr, pos, best, k;
    logic [CntW-1:0] age, best_age;
    logic [OffW-1:0] off;
    logic [TempW-1:0] victim;
    best_age = '0;
    if (it.kind) begin
      placement_q.push_back(placement('0, 1'b0, '0, '0, 1'b1, 1'b1));
      for (k = 0; k < MaxRegs; k++) reg_held[k] = 1'b0;
      grant_seq = '0;
      slot_cnt  = '0;
      return;
    end
    start_pos = int'($signed(it.def_point));
    if (!it.in_class || start_pos < 0) return;
    lu_pos  = int'($signed(it.use_point));
    fin_pos = (lu_pos >= start_pos) ? lu_pos : start_pos;

    // Expired holders go first, including those outside a shrunken pool.
    for (k = 0; k < MaxRegs; k++) begin
      if (reg_held[k] && int'(held_end[k]) < start_pos) reg_held[k] = 1'b0;
    end
    nr = (m_num > MaxRegs) ? MaxRegs : int'(m_num);

    if (it.spill_req || nr == 0) begin
      off = next_slot();
      placement_q.push_back(placement(it.temp, 1'b1, '0, off, 1'b0, 1'b1));
      return;
    end

    pos = -1;
    for (k = 0; k < nr; k++) begin
      if (!reg_held[k] && pos < 0) pos = k;
    end
    if (pos >= 0) begin
      reg_held[pos]   = 1'b1;
      held_end[pos]   = fin_pos[EndW-1:0];
      held_temp[pos]  = it.temp;
      held_order[pos] = grant_seq;
      grant_seq = grant_seq + CntW'(1);
      placement_q.push_back(placement(it.temp, 1'b0, RegIdxW'(int'(m_first) + pos),
                                      '0, 1'b0, 1'b1));
      return;
    end

    // Largest end wins; among equal ends the youngest grant, age taken modulo
    // the counter width.
    best = -1;
    for (k = 0; k < nr; k++) begin
      if (reg_held[k]) begin
        age = grant_seq - held_order[k];
        if (best < 0 || held_end[k] > held_end[best] ||
            (held_end[k] == held_end[best] && age < best_age)) begin
          best     = k;
          best_age = age;
        end
      end
    end
    if (best >= 0 && int'(held_end[best]) > fin_pos) begin
      victim           = held_temp[best];
      held_end[best]   = fin_pos[EndW-1:0];
      held_temp[best]  = it.temp;
      held_order[best] = grant_seq;
      grant_seq = grant_seq + CntW'(1);
      off = next_slot();
      placement_q.push_back(placement(it.temp, 1'b0, RegIdxW'(int'(m_first) + best),
                                      '0, 1'b0, 1'b0));
      placement_q.push_back(placement(victim, 1'b1, '0, off, 1'b0, 1'b1));
      return;
    end
    off = next_slot();
    placement_q.push_back(placement(it.temp, 1'b1, '0, off, 1'b0, 1'b1));
  endtask

  // Interval request driver.
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s_axis_tvalid <= 1'b0;
      drv_gap = 0;
    end else begin
      drv_offer = s_axis_tvalid;
      if (s_axis_tvalid && s_axis_tready) begin
        place_interval(drv_item);
        sent_cnt++;
        drv_offer = 1'b0;
        drv_gap = (drv_gaps_on && $urandom_range(0, 99) < 40) ? pick_gap() : 0;
      end
      if (!drv_offer) begin
        if (drv_gap > 0) begin
          drv_gap--;
        end else if (interval_q.size() != 0) begin
          drv_item = interval_q.pop_front();
          s_axis_tdata <= {drv_item.spill_req, drv_item.use_point, drv_item.def_point,
                           drv_item.in_class, drv_item.temp};
          s_axis_tuser <= drv_item.kind;
          drv_offer = 1'b1;
        end
      end
      s_axis_tvalid <= drv_offer;
    end
  end

  // Long receiver hold, started by a one-cycle pulse on hold_go.
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      hold_cnt <= '0;
    end else if (hold_go) begin
      hold_cnt <= 9'(LongHold);
    end else if (hold_cnt != 0) begin
      hold_cnt <= hold_cnt - 9'(1);
    end
  end

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      m_axis_tready <= 1'b0;
      rcv_gap = 0;
    end else if (hold_cnt != 0) begin
      m_axis_tready <= 1'b0;
    end else if (rcv_gap > 0) begin
      rcv_gap--;
      m_axis_tready <= 1'b0;
    end else begin
      m_axis_tready <= 1'b1;
      if (rcv_gaps_on && $urandom_range(0, 99) < 25) rcv_gap = pick_gap();
    end
  end

  // Result monitor.
  always @(posedge clk_i) begin
    if (rst_ni && m_axis_tvalid && m_axis_tready) begin
      mon_got.temp    = m_axis_tdata[11:0];
      mon_got.spilled = m_axis_tdata[12];
      mon_got.reg_idx = m_axis_tdata[16:13];
      mon_got.offset  = m_axis_tdata[32:17];
      mon_got.total   = m_axis_tdata[45:33];
      mon_got.summary = m_axis_tuser;
      mon_got.last    = m_axis_tlast;
      if (m_axis_tdata[47:46] != '0) report_mismatch("padding bits of tdata not zero");
      if (placement_q.size() == 0) begin
        report_mismatch($sformatf("unexpected result for temp %0d", mon_got.temp));
      end else begin
        mon_want = placement_q.pop_front();
        check_field("result_temp", int'(mon_got.temp), int'(mon_want.temp));
        check_field("spilled", int'(mon_got.spilled), int'(mon_want.spilled));
        check_field("reg_index", int'(mon_got.reg_idx), int'(mon_want.reg_idx));
        check_field("spill_offset", int'(mon_got.offset), int'(mon_want.offset));
        check_field("is_summary", int'(mon_got.summary), int'(mon_want.summary));
        check_field("total_spills", int'(mon_got.total), int'(mon_want.total));
        check_field("last", int'(mon_got.last), int'(mon_want.last));
        checked_cnt++;
        if (!mon_want.last) evict_cnt++;
        if (mon_want.spilled) spill_cnt++;
        if (mon_want.summary) summary_cnt++;
      end
    end
  end

  task automatic queue_interval(input logic kind, input int temp,
                                input logic cls, input int fd, input int lu,
                                input logic frc);
    interval_t it;
    it.kind      = kind;
    it.temp      = temp[TempW-1:0];
    it.in_class  = cls;
    it.def_point = fd[PointW-1:0];
    it.use_point = lu[PointW-1:0];
    it.spill_req = frc;
    interval_q.push_back(it);
    queued_cnt++;
  endtask

  // One function's worth of intervals sorted by start, then by end, with an
  // optional share of unsorted noise and, if close_fn is set, a closing finish request.
  task automatic queue_function(input int n, input int base, input int step_max,
                                input int len_max, input int force_pct,
                                input int noise_pct, input bit close_fn);
    int cur, len, prev_len, step, lu, k;
    cur = base;
    prev_len = 0;
    for (k = 0; k < n; k++) begin
      if ($urandom_range(0, 99) < noise_pct) begin
        queue_interval($urandom_range(0, 7) == 0, $urandom_range(0, 4095),
                       1'($urandom_range(0, 1)), $urandom, $urandom,
                       1'($urandom_range(0, 1)));
      end else begin
        step = (k == 0) ? 0 : $urandom_range(0, step_max);
        cur  = (cur + step > 65535) ? 65535 : cur + step;
        if (k > 0 && step == 0) len = prev_len + $urandom_range(0, 3);
        else len = $urandom_range(0, len_max);
        lu = (cur + len > 65535) ? 65535 : cur + len;
        // A zero-length interval may also come from a temp never used, or
        // from a use that lies before the definition.
        if (len == 0 && $urandom_range(0, 1)) begin
          lu = $urandom_range(0, 1) ? -1 : cur - int'($urandom_range(1, cur + 65536));
        end
        prev_len = len;
        queue_interval(1'b0, $urandom_range(0, 4095), 1'b1, cur, lu,
                       $urandom_range(0, 99) < force_pct);
      end
    end
    if (close_fn) begin
      queue_interval(1'b1, $urandom_range(0, 4095), 1'($urandom_range(0, 1)), $urandom,
                     $urandom, 1'($urandom_range(0, 1)));
    end
  endtask

  // Writes all three registers back to back with valid held high.
  task automatic program_regs(input logic [CfgDataW-1:0] num_d,
                              input logic [CfgDataW-1:0] first_d,
                              input logic [CfgDataW-1:0] size_d);
    logic [CfgDataW-1:0] vals [3];
    cfg_reg_e idxs [3];
    int k;
    vals = '{num_d, first_d, size_d};
    idxs = '{CfgNumRegs, CfgFirstReg, CfgSpillSize};
    cfg_valid_i <= 1'b1;
    for (k = 0; k < 3; k++) begin
      cfg_index_i <= idxs[k];
      cfg_data_i  <= vals[k];
      do @(posedge clk_i); while (!(cfg_valid_i && cfg_ready_o));
      case (idxs[k])
        CfgNumRegs:   m_num   = vals[k][NumW-1:0];
        CfgFirstReg:  m_first = vals[k][FirstW-1:0];
        CfgSpillSize: m_size  = vals[k][SizeW-1:0];
        default: ;
      endcase
    end
    cfg_valid_i <= 1'b0;
  endtask

  task automatic wait_idle();
    do @(posedge clk_i); while (!(sent_cnt == queued_cnt && placement_q.size() == 0));
    repeat (TailCycles) @(posedge clk_i);
  endtask

  initial begin
    while (cycle_cnt < CycleLimit) begin
      @(posedge clk_i);
      cycle_cnt++;
    end
    $display("Timeout after %0d cycles with %0d results outstanding.",
             cycle_cnt, placement_q.size());
    $display("TEST FAILED");
    $finish;
  end

  initial begin
    int ph, cnt, n, r, num4;
    logic [CfgDataW-1:0] num_d, first_d, size_d;
    m_num     = ResetNumRegs;
    m_first   = ResetFirstReg;
    m_size    = ResetSpillSize;
    grant_seq = '0;
    slot_cnt  = '0;
    for (int k = 0; k < MaxRegs; k++) reg_held[k] = 1'b0;
    repeat (5) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Directed cases on the reset settings: five registers from 0, 8-byte slots.
    queue_interval(1'b0, 'h0AB, 1'b0, 5, 9, 1'b0);            // other class
    queue_interval(1'b0, 'h0AC, 1'b1, -1, 9, 1'b0);           // never defined
    queue_interval(1'b0, 'h000, 1'b1, -65536, 3, 1'b1);       // most negative start
    queue_interval(1'b0, 'h000, 1'b1, 0, 10, 1'b0);
    queue_interval(1'b0, 'hFFF, 1'b1, 0, 65535, 1'b1);        // forced spill
    for (int k = 1; k <= 4; k++) queue_interval(1'b0, k, 1'b1, 1, 80, 1'b0);
    queue_interval(1'b0, 20, 1'b1, 2, 90, 1'b0);              // no holder ends later
    queue_interval(1'b0, 21, 1'b1, 3, 20, 1'b0);              // evicts youngest tie
    queue_interval(1'b0, 22, 1'b1, 4, 25, 1'b0);
    queue_interval(1'b0, 23, 1'b1, 11, -1, 1'b0);             // releases an expired one
    queue_interval(1'b1, 'hFFF, 1'b1, -1, -1, 1'b1);          // finish
    queue_interval(1'b0, 'h555, 1'b1, 65535, 65535, 1'b0);
    wait_idle();

    // Shrink the pool under live holders, then grow it again.
    program_regs(5'h14, 5'h07, 5'h10);
    for (int k = 0; k < 4; k++) queue_interval(1'b0, 100 + k, 1'b1, 0, 1000, 1'b0);
    wait_idle();
    program_regs(5'h02, 5'h07, 5'h10);
    queue_interval(1'b0, 200, 1'b1, 10, 20, 1'b0);
    queue_interval(1'b0, 201, 1'b1, 2000, 2000, 1'b0);
    wait_idle();
    program_regs(5'h04, 5'h07, 5'h10);
    for (int k = 0; k < 3; k++) queue_interval(1'b0, 300 + k, 1'b1, 2001, 2010, 1'b0);
    queue_interval(1'b1, 0, 1'b0, 0, 0, 1'b0);
    wait_idle();

    // Random phases, each on settings of its own.
    for (ph = 0; ph < 10; ph++) begin
      case (ph)
        0: begin num_d = 5'h01; first_d = 5'h07; size_d = 5'h01; end
        1: begin num_d = 5'h08; first_d = 5'h00; size_d = 5'h10; end
        2: begin num_d = 5'h10; first_d = 5'h1B; size_d = 5'h1F; end
        3: begin num_d = 5'h1F; first_d = 5'h1F; size_d = 5'h00; end
        default: begin
          r = $urandom_range(0, 9);
          num4 = (r < 6) ? $urandom_range(1, 8) : (r < 8) ? $urandom_range(9, 15) : 0;
          num_d   = {1'($urandom_range(0, 1)), 4'(num4)};
          first_d = CfgDataW'($urandom_range(0, 31));
          size_d  = CfgDataW'($urandom_range(0, 31));
        end
      endcase
      program_regs(num_d, first_d, size_d);
      drv_gaps_on <= (ph % 3 != 0) && (ph != 5);
      rcv_gaps_on <= (ph % 4 != 1);
      if (ph == 5) begin
        // Receiver holds off while the sender streams without gaps.
        hold_go <= 1'b1;
        @(posedge clk_i);
        hold_go <= 1'b0;
      end
      cnt = 0;
      while (cnt < 55) begin
        n = $urandom_range(5, 25);
        r = $urandom_range(0, 3);
        queue_function(n, (r == 0) ? $urandom_range(60000, 65400) : $urandom_range(0, 200),
                       $urandom_range(0, 4),
                       (r == 1) ? $urandom_range(0, 3) : (r == 2) ? 60 : 400,
                       10, 8, $urandom_range(0, 4) != 0);
        cnt += n + 1;
      end
      wait_idle();
    end

    if (placement_q.size() != 0) begin
      report_mismatch($sformatf("%0d expected results never arrived", placement_q.size()));
    end
    $display("Covered %0d requests and %0d checked results in %0d cycles.",
             sent_cnt, checked_cnt, cycle_cnt);
    $display("Seen %0d evictions, %0d spilled placements, %0d finish summaries.",
             evict_cnt, spill_cnt, summary_cnt);
    if (err_cnt == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("%0d mismatches.", err_cnt);
      $display("TEST FAILED");
    end
    $finish;
  end

endmodule

FILE: files.f
rtl/lra_pkg.sv
rtl/linear_scan_register_allocator_core.sv
rtl/lra_checker.sv
verif/tb_linear_scan_register_allocator_core.sv
